### sv/csi_control_sequence_parser_defines.svh
// Assertion macros shared by the CSI parser RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef CSI_CONTROL_SEQUENCE_PARSER_DEFINES_SVH
`define CSI_CONTROL_SEQUENCE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CSI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CSI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/csi_pkg.sv
// Package for the CSI control sequence parser: state and event codes,
// byte constants and the per-byte step result type. No dependencies.
package csi_pkg;

  localparam int unsigned STATE_W = 3;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] ST_ESC    = 3'd1;
  localparam logic [STATE_W-1:0] ST_CSI    = 3'd2;
  localparam logic [STATE_W-1:0] ST_PARAM  = 3'd3;
  localparam logic [STATE_W-1:0] ST_INTERM = 3'd4;
  localparam logic [STATE_W-1:0] ST_FINAL  = 3'd5;

  localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_ESC    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CSI    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_PARAM  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_INTERM = 3'd4;
  localparam logic [EVENT_W-1:0] EV_FINAL  = 3'd5;
  localparam logic [EVENT_W-1:0] EV_ILSEQ  = 3'd6;

  localparam logic [BYTE_W-1:0] BYTE_ESC = 8'h1B;
  localparam logic [BYTE_W-1:0] BYTE_LBR = 8'h5B;
  localparam logic [BYTE_W-1:0] BYTE_SEP = 8'h3B;

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic [EVENT_W-1:0] event_code;
    logic               param_separator;
  } step_t;

endpackage

### sv/csi_step.sv
// Per-byte transition logic of the CSI parser: classifies one byte and
// returns next state, event code and separator flag. Depends on csi_pkg.
module csi_step (
  input  logic [csi_pkg::STATE_W-1:0] state,
  input  logic [csi_pkg::BYTE_W-1:0]  data,
  output csi_pkg::step_t              step
);
  import csi_pkg::*;

  logic is_param;
  logic is_interm;
  logic is_final;
  logic is_sep;

  assign is_param  = (data >= 8'h30) && (data <= 8'h3F);
  assign is_interm = (data >= 8'h20) && (data <= 8'h2F);
  assign is_final  = (data >= 8'h40) && (data <= 8'h7E);
  assign is_sep    = (data == BYTE_SEP);

  always_comb begin
    step.next_state      = state;
    step.event_code      = EV_NONE;
    step.param_separator = 1'b0;
    case (state)
      ST_ESC: begin
        if (data == BYTE_LBR) begin
          step.next_state = ST_CSI;
          step.event_code = EV_CSI;
        end else begin
          step.next_state = ST_IDLE;
          step.event_code = EV_ILSEQ;
        end
      end
      ST_CSI: begin
        if (is_param) begin
          step.next_state      = ST_PARAM;
          step.event_code      = EV_PARAM;
          step.param_separator = is_sep;
        end else if (is_interm) begin
          step.next_state = ST_INTERM;
          step.event_code = EV_INTERM;
        end else if (is_final) begin
          step.next_state = ST_FINAL;
          step.event_code = EV_FINAL;
        end else begin
          step.next_state = ST_IDLE;
          step.event_code = EV_ILSEQ;
        end
      end
      ST_PARAM: begin
        if (is_param) begin
          step.param_separator = is_sep;
        end else begin
          step.param_separator = 1'b1;
          if (is_interm) begin
            step.next_state = ST_INTERM;
            step.event_code = EV_INTERM;
          end else if (is_final) begin
            step.next_state = ST_FINAL;
            step.event_code = EV_FINAL;
          end else begin
            step.next_state = ST_IDLE;
            step.event_code = EV_ILSEQ;
          end
        end
      end
      ST_INTERM: begin
        if (is_interm) begin
          step.next_state = ST_INTERM;
        end else if (is_final) begin
          step.next_state = ST_FINAL;
          step.event_code = EV_FINAL;
        end else begin
          step.next_state = ST_IDLE;
          step.event_code = EV_ILSEQ;
        end
      end
      default: begin
        if (data == BYTE_ESC) begin
          step.next_state = ST_ESC;
          step.event_code = EV_ESC;
        end else begin
          step.next_state = ST_IDLE;
        end
      end
    endcase
  end

endmodule

### sv/csi_control_sequence_parser.sv
// CSI control sequence parser, top level: input register, per-byte step
// logic and result register. Throughput: one byte per cycle while out_stall
// is low, set by the single parse state register updated as each byte moves
// into the result register. Synchronous active-low reset empties both
// registers and returns to idle. Depends on csi_pkg, csi_step and
// csi_control_sequence_parser_defines.svh.
`include "csi_control_sequence_parser_defines.svh"

module csi_control_sequence_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [csi_pkg::BYTE_W-1:0]  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [csi_pkg::EVENT_W-1:0] out_event_code,
  output logic                        out_param_separator
);
  import csi_pkg::*;

  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic [STATE_W-1:0] state_r;
  logic               out_valid_r;
  logic [EVENT_W-1:0] out_event_code_r;
  logic               out_param_separator_r;
  logic               out_free;
  logic               step_move;
  logic               in_take;
  step_t              step;

  csi_step u_step (
    .state (state_r),
    .data  (in_byte_r),
    .step  (step)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign step_move = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (step_move) begin
        state_r <= step.next_state;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_move) begin
      out_event_code_r      <= step.event_code;
      out_param_separator_r <= step.param_separator;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_code      = out_event_code_r;
  assign out_param_separator = out_param_separator_r;

  `CSI_ASSERT_NXT(a_final_tracks_state, step_move,
    (out_event_code_r == EV_FINAL) == (state_r == ST_FINAL),
    "final event and parse state disagree")
  `CSI_ASSERT_NXT(a_ilseq_to_idle, step_move && (step.event_code == EV_ILSEQ),
    state_r == ST_IDLE, "illegal sequence did not return to idle")
  `CSI_ASSERT_NXT(a_held_byte_kept, in_valid_r && !step_move,
    in_valid_r && $stable(in_byte_r), "stalled input byte lost or changed")
  `CSI_ASSERT_IMP(a_sep_only_in_params, step_move && step.param_separator,
    (state_r == ST_PARAM) || (state_r == ST_CSI), "separator outside parameters")

endmodule
